// File: rtl/core/shvs_pkg.sv
// shared types and constants of the smoothed heaviside unit
// quarter-wave sine table and the control word that travels with each item
// no dependencies
package shvs_pkg;

    localparam logic [30:0] HW_RESET   = 31'd65536;
    localparam logic [13:0] INV_TWO_PI = 14'd10430;
    localparam logic [16:0] SINE_ONE   = 17'd65536;
    localparam logic [14:0] QUARTER    = 15'd16384;

    typedef struct packed {
        logic valid;
        logic eog;
        logic f_zero;
        logic f_one;
        logic f_half;
    } t_ctl;

    function automatic logic [16:0] sine_tab(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd6424;
            5'd2:    v = 17'd12785;
            5'd3:    v = 17'd19024;
            5'd4:    v = 17'd25080;
            5'd5:    v = 17'd30893;
            5'd6:    v = 17'd36410;
            5'd7:    v = 17'd41576;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd50660;
            5'd10:   v = 17'd54491;
            5'd11:   v = 17'd57798;
            5'd12:   v = 17'd60547;
            5'd13:   v = 17'd62714;
            5'd14:   v = 17'd64277;
            5'd15:   v = 17'd65220;
            5'd16:   v = 17'd65536;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/smoothed_heaviside_unit.sv
// top level of the smoothed heaviside unit: half-width register, pipeline, result stage
// depends on shvs_pkg, shvs_front, shvs_div, shvs_sine
// Takes one level value per clock (busy is always low) and presents its result on
// o_heaviside with o_strobe high for one cycle, once the item has passed the front
// register, the divider stages, the sine stages and the result register; the divider
// resolves one quotient bit per stage. Results come in input order and cannot be
// held off, so the receiver must take one in every cycle that o_strobe is high. Write
// half_width only while no item is in flight.
module smoothed_heaviside_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [31:0]          i_level_value,
    input  logic                 i_end_of_grid,
    input  logic                 i_cfg_we,
    input  logic [30:0]          i_cfg_wdata,
    output logic                 o_strobe,
    output logic [FRAC_BITS:0]   o_heaviside,
    output logic                 o_end_of_grid_out
);
    import shvs_pkg::*;

    localparam int M  = (FRAC_BITS > 16) ? FRAC_BITS : 16;
    localparam int QB = M + 2;
    localparam int PW = 32 + FRAC_BITS;

    logic [30:0]        r_half_width;
    logic [32:0]        fr_u;
    t_ctl               fr_ctl;
    logic [QB-1:0]      dv_quo;
    t_ctl               dv_ctl;
    logic [FRAC_BITS:0] sn_t;
    logic               sn_neg;
    logic [30:0]        sn_prod;
    t_ctl               sn_ctl;

    logic [PW-1:0]             round_sum;
    logic [FRAC_BITS-1:0]      term;
    logic signed [FRAC_BITS+2:0] h_s;
    logic [FRAC_BITS:0]        n_heaviside;
    logic                      r_strobe;
    logic [FRAC_BITS:0]        r_heaviside;
    logic                      r_eog;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= HW_RESET;
        end else if (i_cfg_we) begin
            r_half_width <= i_cfg_wdata;
        end
    end

    shvs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (start && !busy),
        .i_phi   (i_level_value),
        .i_eog   (i_end_of_grid),
        .i_eps   (r_half_width),
        .o_u     (fr_u),
        .o_ctl   (fr_ctl)
    );

    shvs_div #(.QB(QB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_u     (fr_u),
        .i_den   ({r_half_width, 1'b0}),
        .i_ctl   (fr_ctl),
        .o_quo   (dv_quo),
        .o_ctl   (dv_ctl)
    );

    shvs_sine #(.F(FRAC_BITS), .M(M)) u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quo   (dv_quo),
        .i_ctl   (dv_ctl),
        .o_t     (sn_t),
        .o_neg   (sn_neg),
        .o_prod  (sn_prod),
        .o_ctl   (sn_ctl)
    );

    always_comb begin
        round_sum = {1'b0, sn_prod, {FRAC_BITS{1'b0}}} + (PW'(1) << 31);
        term      = round_sum[PW-1:32];
        if (sn_neg) begin
            h_s = $signed({2'b00, sn_t}) + $signed({3'b000, term});
        end else begin
            h_s = $signed({2'b00, sn_t}) - $signed({3'b000, term});
        end
        if (sn_ctl.f_zero) begin
            n_heaviside = '0;
        end else if (sn_ctl.f_one) begin
            n_heaviside = (FRAC_BITS+1)'(1) << FRAC_BITS;
        end else if (sn_ctl.f_half) begin
            n_heaviside = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
        end else if (h_s < 0) begin
            n_heaviside = '0;
        end else if (h_s > $signed((FRAC_BITS+3)'(1) << FRAC_BITS)) begin
            n_heaviside = (FRAC_BITS+1)'(1) << FRAC_BITS;
        end else begin
            n_heaviside = h_s[FRAC_BITS:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= sn_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_heaviside <= n_heaviside;
        r_eog       <= sn_ctl.eog;
    end

    assign o_strobe          = r_strobe;
    assign o_heaviside       = r_heaviside;
    assign o_end_of_grid_out = r_eog;

endmodule

// File: rtl/core/shvs_front.sv
// input stage: band test against the half-width and offset u = phi + eps
// depends on shvs_pkg
module shvs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [31:0]       i_phi,
    input  logic              i_eog,
    input  logic [30:0]       i_eps,
    output logic [32:0]       o_u,
    output shvs_pkg::t_ctl    o_ctl
);
    import shvs_pkg::*;

    logic signed [32:0] phi_e;
    logic signed [32:0] eps_e;
    logic signed [32:0] sum;
    t_ctl               n_ctl;
    t_ctl               r_ctl;
    logic [32:0]        r_u;

    always_comb begin
        phi_e        = {i_phi[31], i_phi};
        eps_e        = {2'b00, i_eps};
        sum          = phi_e + eps_e;
        n_ctl.valid  = i_take;
        n_ctl.eog    = i_eog;
        n_ctl.f_zero = phi_e < -eps_e;
        n_ctl.f_one  = phi_e > eps_e;
        n_ctl.f_half = (i_eps == 31'd0) && (i_phi == 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= sum;
    end

    assign o_u   = r_u;
    assign o_ctl = r_ctl;

endmodule

// File: rtl/core/shvs_div.sv
// pipelined restoring divider, one quotient bit per stage
// quotient = floor(u * 2^(QB-1) / den) for u <= den; depends on shvs_pkg
module shvs_div #(
    parameter int QB = 18
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [32:0]       i_u,
    input  logic [31:0]       i_den,
    input  shvs_pkg::t_ctl    i_ctl,
    output logic [QB-1:0]     o_quo,
    output shvs_pkg::t_ctl    o_ctl
);
    import shvs_pkg::*;

    logic [31:0]   r_rem [QB];
    logic [QB-1:0] r_quo [QB];
    t_ctl          r_ctl [QB];
    logic [31:0]   n_rem [QB];
    logic [QB-1:0] n_quo [QB];
    logic [32:0]   step_val [QB];
    logic [32:0]   step_dif [QB];
    logic          step_bit [QB];
    logic [32:0]   den33;

    always_comb begin
        den33       = {1'b0, i_den};
        step_val[0] = i_u;
        step_dif[0] = i_u - den33;
        step_bit[0] = i_u >= den33;
        n_rem[0]    = step_bit[0] ? step_dif[0][31:0] : i_u[31:0];
        n_quo[0]    = QB'(step_bit[0]);
        for (int k = 1; k < QB; k++) begin
            step_val[k] = {r_rem[k-1], 1'b0};
            step_dif[k] = step_val[k] - den33;
            step_bit[k] = step_val[k] >= den33;
            n_rem[k]    = step_bit[k] ? step_dif[k][31:0] : step_val[k][31:0];
            n_quo[k]    = {r_quo[k-1][QB-2:0], step_bit[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QB; k++) begin
                r_ctl[k] <= '0;
            end
        end else begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k < QB; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QB; k++) begin
            r_rem[k] <= n_rem[k];
            r_quo[k] <= n_quo[k];
        end
    end

    assign o_quo = r_quo[QB-1];
    assign o_ctl = r_ctl[QB-1];

endmodule

// File: rtl/core/shvs_sine.sv
// rounding of t and phase, quarter-wave lookup with interpolation, scale by 1/(2 pi)
// three register stages; depends on shvs_pkg
module shvs_sine #(
    parameter int F = 16,
    parameter int M = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [M+1:0]      i_quo,
    input  shvs_pkg::t_ctl    i_ctl,
    output logic [F:0]        o_t,
    output logic              o_neg,
    output logic [30:0]       o_prod,
    output shvs_pkg::t_ctl    o_ctl
);
    import shvs_pkg::*;

    logic [M+1:0]  zt_full;
    logic [M+1:0]  zp_full;
    logic [F+2:0]  tsum;
    logic [18:0]   psum;
    logic [15:0]   phase;
    logic [14:0]   n_r15;
    logic [3:0]    idx;
    logic [16:0]   tab_a;
    logic [16:0]   tab_b;
    logic [16:0]   diff;
    logic [26:0]   interp;
    logic [16:0]   n_mag;

    t_ctl          r_ctl1, r_ctl2, r_ctl3;
    logic [F:0]    r_t1, r_t2, r_t3;
    logic [1:0]    r_q1;
    logic          r_neg2, r_neg3;
    logic [14:0]   r_r15;
    logic [16:0]   r_mag;
    logic [30:0]   r_prod;

    always_comb begin
        zt_full = i_quo >> (M - F);
        zp_full = i_quo >> (M - 16);
        tsum    = {1'b0, zt_full[F+1:0]} + (F+3)'(1);
        psum    = {1'b0, zp_full[17:0]} + 19'd1;
        phase   = psum[16:1];
        if (phase[14]) begin
            n_r15 = QUARTER - {1'b0, phase[13:0]};
        end else begin
            n_r15 = {1'b0, phase[13:0]};
        end
    end

    always_comb begin
        idx    = r_r15[13:10];
        tab_a  = sine_tab({1'b0, idx});
        tab_b  = sine_tab({1'b0, idx} + 5'd1);
        diff   = tab_b - tab_a;
        interp = 27'(diff) * 27'(r_r15[9:0]);
        if (r_r15[14]) begin
            n_mag = SINE_ONE;
        end else begin
            n_mag = tab_a + interp[26:10];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1   <= tsum[F+1:1];
        r_q1   <= phase[15:14];
        r_r15  <= n_r15;
        r_t2   <= r_t1;
        r_neg2 <= r_q1[1];
        r_mag  <= n_mag;
        r_t3   <= r_t2;
        r_neg3 <= r_neg2;
        r_prod <= 31'(r_mag) * 31'(INV_TWO_PI);
    end

    assign o_t    = r_t3;
    assign o_neg  = r_neg3;
    assign o_prod = r_prod;
    assign o_ctl  = r_ctl3;

endmodule

// File: dv/smoothed_heaviside_unit_tb.sv
// self-checking testbench of smoothed_heaviside_unit: directed and random level values
// over several half-width settings, predicted results compared in order with the outputs
// depends on shvs_pkg and rtl/core/smoothed_heaviside_unit.sv
`timescale 1ns / 100ps

module smoothed_heaviside_unit_tb;
    import shvs_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [FRAC_BITS:0] heaviside;
        logic               eog;
    } t_step_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [31:0]          i_level_value;
    logic                 i_end_of_grid;
    logic                 i_cfg_we;
    logic [30:0]          i_cfg_wdata;
    logic                 o_strobe;
    logic [FRAC_BITS:0]   o_heaviside;
    logic                 o_end_of_grid_out;

    t_step_result pending_q[$];
    logic [30:0]  eps_model;
    int           error_count;
    int           cycle_count;

    logic [16:0] quarter_wave [0:16] = '{
        17'd0, 17'd6424, 17'd12785, 17'd19024, 17'd25080, 17'd30893, 17'd36410,
        17'd41576, 17'd46341, 17'd50660, 17'd54491, 17'd57798, 17'd60547,
        17'd62714, 17'd64277, 17'd65220, 17'd65536
    };

    smoothed_heaviside_unit #(.FRAC_BITS(FRAC_BITS)) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_level_value     (i_level_value),
        .i_end_of_grid     (i_end_of_grid),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_strobe          (o_strobe),
        .o_heaviside       (o_heaviside),
        .o_end_of_grid_out (o_end_of_grid_out)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [FRAC_BITS:0] smooth_heaviside(input logic [31:0] raw,
                                                           input logic [30:0] eps);
        longint     phi;
        longint     e;
        logic [63:0] u, den, t, ph, r, mag, term, i, f;
        logic [1:0]  quad;
        longint     h;
        longint     one;
        one = longint'(1) << FRAC_BITS;
        phi = longint'($signed(raw));
        e = longint'(eps);
        if (e == 0) begin
            if (phi < 0) return '0;
            if (phi > 0) return one[FRAC_BITS:0];
            return one[FRAC_BITS:0] >> 1;
        end
        if (phi < -e) return '0;
        if (phi > e) return one[FRAC_BITS:0];
        u = 64'(phi + e);
        den = 64'(2 * e);
        t = ((u << FRAC_BITS) + 64'(e)) / den;
        ph = (((u << 16) + 64'(e)) / den) & 64'hFFFF;
        quad = ph[15:14];
        r = ph & 64'd16383;
        if (quad[0]) r = 64'd16384 - r;
        if (r >= 64'd16384) begin
            mag = 64'd65536;
        end else begin
            i = r >> 10;
            f = r & 64'd1023;
            mag = 64'(quarter_wave[5'(i[3:0])]) +
                  (((64'(quarter_wave[5'(i[3:0]) + 5'd1]) -
                     64'(quarter_wave[5'(i[3:0])])) * f) >> 10);
        end
        term = (((mag * 64'd10430) << FRAC_BITS) + (64'd1 << 31)) >> 32;
        if (quad < 2) h = longint'(t) - longint'(term);
        else h = longint'(t) + longint'(term);
        if (h < 0) h = 0;
        if (h > one) h = one;
        return h[FRAC_BITS:0];
    endfunction

    task automatic send_item(input logic [31:0] phi, input logic eog);
        logic b;
        t_step_result exp_r;
        @(negedge i_clk);
        start = 1'b1;
        i_level_value = phi;
        i_end_of_grid = eog;
        forever begin
            #1 b = busy;
            @(posedge i_clk);
            if (!b) break;
            @(negedge i_clk);
        end
        exp_r.heaviside = smooth_heaviside(phi, eps_model);
        exp_r.eog = eog;
        pending_q.push_back(exp_r);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        wait (pending_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_half_width(input logic [30:0] value);
        wait_drained();
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        @(posedge i_clk);
        eps_model = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        i_cfg_wdata = 31'($urandom);
    endtask

    task automatic test_reset_width();
        logic [31:0] e;
        e = 32'(eps_model);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);
        send_item(32'd0, 1'b0);
        send_item(-e, 1'b1);
        send_item(e, 1'b0);
        send_item(-e - 1, 1'b0);
        send_item(e + 1, 1'b1);
        send_item(e >> 1, 1'b0);
        send_item(-(e >> 1), 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'd1, 1'b0);
    endtask

    task automatic test_width_extremes();
        write_half_width(31'd0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'd0, 1'b1);
        send_item(32'd1, 1'b0);
        write_half_width(31'd1);
        send_item(32'hFFFF_FFFE, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'd0, 1'b0);
        send_item(32'd1, 1'b1);
        send_item(32'd2, 1'b0);
        write_half_width(31'h7FFF_FFFF);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h8000_0001, 1'b1);
        send_item(32'd0, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);
    endtask

    function automatic logic [31:0] random_level(input logic [30:0] eps);
        longint e;
        longint span;
        e = longint'(eps);
        span = 2 * e + 1;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return 32'(-e - longint'($urandom_range(0, 2)));
            3:       return 32'(e + longint'($urandom_range(0, 2)) - 1);
            default: return 32'(-e + longint'({$urandom, $urandom} % 64'(span)));
        endcase
    endfunction

    task automatic random_burst_run(input int n_items, input bit pause_midway);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && sent < n_items) begin
                send_item(random_level(eps_model), 1'($urandom));
                burst--;
                sent++;
                if (pause_midway && sent == n_items / 2) begin
                    @(negedge i_clk);
                    start = 1'b0;
                    wait (pending_q.size() == 0);
                end
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
        end
    endtask

    task automatic test_random_sweep();
        logic [30:0] widths [8];
        widths = '{31'd65536, 31'd1, 31'h7FFF_FFFF, 31'd0, 31'd3, 31'h0010_0000,
                   31'd1000, 31'($urandom)};
        foreach (widths[k]) begin
            write_half_width(widths[k]);
            random_burst_run(120, k == 2);
        end
    endtask

    always @(posedge i_clk) begin
        t_step_result exp_r;
        if (i_rst_n && o_strobe) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result heaviside=%0d", o_heaviside);
                error_count++;
            end else begin
                exp_r = pending_q.pop_front();
                if (o_heaviside !== exp_r.heaviside) begin
                    $error("heaviside expected %0d actual %0d", exp_r.heaviside, o_heaviside);
                    error_count++;
                end
                if (o_end_of_grid_out !== exp_r.eog) begin
                    $error("end_of_grid_out expected %0d actual %0d", exp_r.eog,
                           o_end_of_grid_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_level_value = '0;
        i_end_of_grid = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        eps_model = HW_RESET;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_width();
        test_width_extremes();
        test_random_sweep();

        wait_drained();
        if (pending_q.size() == 0 && error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
